### hw/rtl/lrsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LR shift/reduce engine package
// Shared opcodes, event kinds and sequencer states.
// ----------------------------------------------------------------------------
package lrsr_pkg;

    typedef enum logic [1:0] {
        OP_WRITE_ACTION = 2'd0,
        OP_WRITE_RULE   = 2'd1,
        OP_TOKEN        = 2'd2,
        OP_END          = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        EV_SHIFT     = 3'd0,
        EV_REDUCE    = 3'd1,
        EV_DONE      = 3'd2,
        EV_OVERFLOW  = 3'd3,
        EV_UNDERFLOW = 3'd4,
        EV_LIMIT     = 3'd5
    } event_kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_TOP_RD,
        ST_ACT_RD,
        ST_ACT_WAIT,
        ST_RULE_WAIT,
        ST_BELOW_RD,
        ST_BELOW_WAIT,
        ST_GOTO_RD,
        ST_GOTO_WAIT,
        ST_EMIT
    } seq_state_t;

    localparam int unsigned REDUCE_LIMIT = 63;
    localparam int unsigned LIMIT_W      = 6;
    localparam int unsigned ACTION_W     = 9;
    localparam int unsigned STATE_W      = 8;
    localparam int unsigned SYMBOL_W     = 6;
    localparam int unsigned RULE_W       = 7;
    localparam int unsigned LEN_W        = 4;
    localparam int unsigned DEPTH_W      = 11;

endpackage

### hw/rtl/lrsr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lrsr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/lr_shift_reduce_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LR shift/reduce engine top level
// Table-driven LR parser core with action, rule and state-stack memories.
// ----------------------------------------------------------------------------
// A table write completes in the cycle in which it is accepted. A token is
// handled by one sequencer that walks a chain of registered memory reads in
// turn: top of stack and action for each step, then rule, the state below the
// popped symbols and the goto entry for each reduction before the shift. An
// end item emits its event and then starts the sweep. After reset and after
// each end item, the state stack is swept clear one entry a cycle, and no
// request is taken during the sweep. Each event is staged and then moved
// into an output register. The sequencer waits in its emit step for as long
// as the previous event there has not been taken.
module lr_shift_reduce_engine_core #(
    parameter int unsigned NUM_STATES   = 256,
    parameter int unsigned NUM_SYMBOLS  = 64,
    parameter int unsigned NUM_RULES    = 128,
    parameter int unsigned STACK_DEPTH  = 1024,
    parameter int unsigned MAX_RULE_LEN = 15
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // opcode[1:0], table_state[9:2], table_symbol[15:10], action_value[24:16],
    // rule_index[31:25], rule_length[35:32], rule_left_symbol[41:36],
    // token_symbol[47:42]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // event_kind[2:0], pushed_state[10:3], reduced_rule[17:11],
    // event_symbol[23:18], stack_depth[34:24]
    output logic [39:0] m_tdata,
    output logic        m_tlast
);
    import lrsr_pkg::*;

    localparam int unsigned RU_AW  = $clog2(NUM_RULES);
    localparam int unsigned SK_AW  = $clog2(STACK_DEPTH);
    localparam int unsigned SP_W   = SK_AW + 1;
    localparam int unsigned ACT_D  = NUM_STATES * NUM_SYMBOLS;
    localparam int unsigned ACT_AW = $clog2(ACT_D);

    // Input fields.
    logic [1:0]           in_opcode;
    logic [STATE_W-1:0]   in_table_state;
    logic [SYMBOL_W-1:0]  in_table_symbol;
    logic [ACTION_W-1:0]  in_action_value;
    logic [RULE_W-1:0]    in_rule_index;
    logic [LEN_W-1:0]     in_rule_length;
    logic [SYMBOL_W-1:0]  in_rule_left;
    logic [SYMBOL_W-1:0]  in_token;

    assign in_opcode       = s_tdata[1:0];
    assign in_table_state  = s_tdata[9:2];
    assign in_table_symbol = s_tdata[15:10];
    assign in_action_value = s_tdata[24:16];
    assign in_rule_index   = s_tdata[31:25];
    assign in_rule_length  = s_tdata[35:32];
    assign in_rule_left    = s_tdata[41:36];
    assign in_token        = s_tdata[47:42];

    // Sequencer registers.
    seq_state_t            state_reg, state_next;
    logic [SP_W-1:0]       sp_reg, sp_next;
    logic [SK_AW-1:0]      clr_reg, clr_next;
    logic [LIMIT_W-1:0]    nred_reg, nred_next;
    logic [SYMBOL_W-1:0]   tok_reg, tok_next;
    logic [RULE_W-1:0]     rule_reg, rule_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [SYMBOL_W-1:0]   left_reg, left_next;
    logic [SP_W-1:0]       nsp_reg, nsp_next;

    // Staged event, built by the sequencer.
    logic [2:0]            ok_reg, ok_next;
    logic [STATE_W-1:0]    op_reg, op_next;
    logic [RULE_W-1:0]     orl_reg, orl_next;
    logic [SYMBOL_W-1:0]   osy_reg, osy_next;
    logic [DEPTH_W-1:0]    odp_reg, odp_next;
    logic                  ol_reg, ol_next;

    // Output register, held until the event is taken.
    logic                  ov_reg, ov_next;
    logic [2:0]            mk_reg, mk_next;
    logic [STATE_W-1:0]    mp_reg, mp_next;
    logic [RULE_W-1:0]     mrl_reg, mrl_next;
    logic [SYMBOL_W-1:0]   msy_reg, msy_next;
    logic [DEPTH_W-1:0]    mdp_reg, mdp_next;
    logic                  ml_reg, ml_next;

    // Memory ports.
    logic                  act_we;
    logic [ACT_AW-1:0]     act_wa, act_ra;
    logic [ACTION_W-1:0]   act_wd, act_rd;
    logic                  rule_we;
    logic [RU_AW-1:0]      rule_wa, rule_ra;
    logic [LEN_W+SYMBOL_W-1:0] rule_wd, rule_rd;
    logic                  stk_we;
    logic [SK_AW-1:0]      stk_wa, stk_ra;
    logic [STATE_W-1:0]    stk_wd, stk_rd;

    lrsr_ram #(.WIDTH(ACTION_W), .DEPTH(ACT_D)) u_action (
        .aclk(aclk), .wr_en(act_we), .wr_addr(act_wa), .wr_data(act_wd),
        .rd_addr(act_ra), .rd_data(act_rd));
    lrsr_ram #(.WIDTH(LEN_W + SYMBOL_W), .DEPTH(NUM_RULES)) u_rule (
        .aclk(aclk), .wr_en(rule_we), .wr_addr(rule_wa), .wr_data(rule_wd),
        .rd_addr(rule_ra), .rd_data(rule_rd));
    lrsr_ram #(.WIDTH(STATE_W), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk(aclk), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
        .rd_addr(stk_ra), .rd_data(stk_rd));

    // Action address from a state and a symbol (modulo the table sizes).
    function automatic logic [ACT_AW-1:0] act_addr(
        input logic [STATE_W-1:0] st, input logic [SYMBOL_W-1:0] sy);
        logic [31:0] s32;
        logic [31:0] y32;
        logic [31:0] a32;
        s32 = 32'(st) % NUM_STATES;
        y32 = 32'(sy) % NUM_SYMBOLS;
        a32 = s32 * NUM_SYMBOLS + y32;
        return a32[ACT_AW-1:0];
    endfunction

    logic [LEN_W-1:0]  wlen;
    logic [RULE_W-1:0] dec_rule;
    logic [SP_W-1:0]   pop_sp;
    logic              out_free;

    assign wlen     = (32'(in_rule_length) > MAX_RULE_LEN)
                      ? LEN_W'(MAX_RULE_LEN) : in_rule_length;
    assign dec_rule = RULE_W'(32'(~act_rd[STATE_W-1:0]) % NUM_RULES);
    assign pop_sp   = sp_reg - SP_W'(len_reg);
    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // State register and datapath registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            sp_reg    <= SP_W'(1);
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
        end
        nred_reg <= nred_next;
        tok_reg  <= tok_next;
        rule_reg <= rule_next;
        len_reg  <= len_next;
        left_reg <= left_next;
        nsp_reg  <= nsp_next;
        ok_reg   <= ok_next;
        op_reg   <= op_next;
        orl_reg  <= orl_next;
        osy_reg  <= osy_next;
        odp_reg  <= odp_next;
        ol_reg   <= ol_next;
        mk_reg   <= mk_next;
        mp_reg   <= mp_next;
        mrl_reg  <= mrl_next;
        msy_reg  <= msy_next;
        mdp_reg  <= mdp_next;
        ml_reg   <= ml_next;
    end

    // Sequencer next state, memory controls and event emission.
    always_comb begin
        state_next = state_reg;
        sp_next    = sp_reg;
        clr_next   = clr_reg;
        nred_next  = nred_reg;
        tok_next   = tok_reg;
        rule_next  = rule_reg;
        len_next   = len_reg;
        left_next  = left_reg;
        nsp_next   = nsp_reg;
        ov_next    = ov_reg && !m_tready;
        ok_next    = ok_reg;
        op_next    = op_reg;
        orl_next   = orl_reg;
        osy_next   = osy_reg;
        odp_next   = odp_reg;
        ol_next    = ol_reg;
        mk_next    = mk_reg;
        mp_next    = mp_reg;
        mrl_next   = mrl_reg;
        msy_next   = msy_reg;
        mdp_next   = mdp_reg;
        ml_next    = ml_reg;
        act_we     = 1'b0;
        act_wa     = act_addr(in_table_state, in_table_symbol);
        act_wd     = in_action_value;
        act_ra     = act_addr(stk_rd, tok_reg);
        rule_we    = 1'b0;
        rule_wa    = RU_AW'(32'(in_rule_index) % NUM_RULES);
        rule_wd    = {in_rule_left, wlen};
        rule_ra    = RU_AW'(32'(dec_rule));
        stk_we     = 1'b0;
        stk_wa     = clr_reg;
        stk_wd     = '0;
        stk_ra     = SK_AW'(sp_reg - SP_W'(1));

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    tok_next  = in_token;
                    nred_next = '0;
                    unique case (opcode_t'(in_opcode))
                        OP_WRITE_ACTION: act_we = 1'b1;
                        OP_WRITE_RULE:   rule_we = 1'b1;
                        OP_TOKEN:        state_next = ST_TOP_RD;
                        OP_END: begin
                            ok_next    = EV_DONE;
                            op_next    = '0;
                            orl_next   = '0;
                            osy_next   = '0;
                            odp_next   = DEPTH_W'(sp_reg);
                            ol_next    = 1'b1;
                            state_next = ST_EMIT;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    ov_next  = 1'b1;
                    mk_next  = ok_reg;
                    mp_next  = op_reg;
                    mrl_next = orl_reg;
                    msy_next = osy_reg;
                    mdp_next = odp_reg;
                    ml_next  = ol_reg;
                    if (ok_next == EV_DONE) begin
                        sp_next    = SP_W'(1);
                        clr_next   = '0;
                        state_next = ST_CLEAR;
                    end else begin
                        state_next = ol_reg ? ST_IDLE : ST_TOP_RD;
                    end
                end
            end
            ST_CLEAR: begin
                stk_we   = 1'b1;
                clr_next = clr_reg + SK_AW'(1);
                if (32'(clr_reg) == STACK_DEPTH - 1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_TOP_RD:  state_next = ST_ACT_RD;
            ST_ACT_RD:  state_next = ST_ACT_WAIT;
            ST_ACT_WAIT: begin
                op_next  = '0;
                orl_next = '0;
                osy_next = tok_reg;
                odp_next = DEPTH_W'(sp_reg);
                ol_next  = 1'b1;
                if (!act_rd[ACTION_W-1]) begin
                    if (32'(sp_reg) >= STACK_DEPTH) begin
                        ok_next = EV_OVERFLOW;
                    end else begin
                        stk_we   = 1'b1;
                        stk_wa   = SK_AW'(sp_reg);
                        stk_wd   = act_rd[STATE_W-1:0];
                        sp_next  = sp_reg + SP_W'(1);
                        ok_next  = EV_SHIFT;
                        op_next  = act_rd[STATE_W-1:0];
                        odp_next = DEPTH_W'(sp_reg + SP_W'(1));
                    end
                    state_next = ST_EMIT;
                end else if (32'(nred_reg) >= REDUCE_LIMIT) begin
                    ok_next    = EV_LIMIT;
                    state_next = ST_EMIT;
                end else begin
                    rule_next  = dec_rule;
                    state_next = ST_RULE_WAIT;
                end
            end
            ST_RULE_WAIT: begin
                len_next   = rule_rd[LEN_W-1:0];
                left_next  = rule_rd[LEN_W+SYMBOL_W-1:LEN_W];
                state_next = ST_BELOW_RD;
            end
            ST_BELOW_RD: begin
                stk_ra = SK_AW'(pop_sp - SP_W'(1));
                if (SP_W'(len_reg) >= sp_reg) begin
                    ok_next    = EV_UNDERFLOW;
                    op_next    = '0;
                    orl_next   = '0;
                    osy_next   = tok_reg;
                    odp_next   = DEPTH_W'(sp_reg);
                    ol_next    = 1'b1;
                    state_next = ST_EMIT;
                end else if (32'(pop_sp) >= STACK_DEPTH) begin
                    // A zero-length rule on a full stack has no room for the goto.
                    ok_next    = EV_OVERFLOW;
                    op_next    = '0;
                    orl_next   = '0;
                    osy_next   = tok_reg;
                    odp_next   = DEPTH_W'(sp_reg);
                    ol_next    = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    nsp_next   = pop_sp;
                    state_next = ST_BELOW_WAIT;
                end
            end
            ST_BELOW_WAIT: begin
                stk_ra     = SK_AW'(nsp_reg - SP_W'(1));
                act_ra     = act_addr(stk_rd, left_reg);
                state_next = ST_GOTO_RD;
            end
            ST_GOTO_RD: begin
                // Keep the goto address so its entry is still there next cycle.
                act_ra     = act_addr(stk_rd, left_reg);
                state_next = ST_GOTO_WAIT;
            end
            ST_GOTO_WAIT: begin
                stk_we     = 1'b1;
                stk_wa     = SK_AW'(nsp_reg);
                stk_wd     = act_rd[STATE_W-1:0];
                sp_next    = nsp_reg + SP_W'(1);
                nred_next  = nred_reg + LIMIT_W'(1);
                ok_next    = EV_REDUCE;
                op_next    = act_rd[STATE_W-1:0];
                orl_next   = rule_reg;
                osy_next   = left_reg;
                odp_next   = DEPTH_W'(nsp_reg + SP_W'(1));
                ol_next    = 1'b0;
                state_next = ST_EMIT;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = ml_reg;
    assign m_tdata  = {5'b0, mdp_reg, msy_reg, mrl_reg, mp_reg, mk_reg};

    // A new event is never loaded over one still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !m_tready) |=> ov_reg)
        else $error("output event lost");
    // A waiting event keeps its contents.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (ov_reg && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
        else $error("output event changed while waiting");
    // The stack pointer never falls to zero.
    a_sp_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg != '0)
        else $error("stack pointer zero");
    // No input accepted while busy.
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE)
        else $error("ready while busy");

endmodule

### bench/tb_lr_shift_reduce_engine_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LR shift/reduce engine testbench
// Builds grammar tables on demand while it generates token streams, so that
// no table entry is read before it is written. A parse predictor runs the
// same stack walk and records the events each request must produce. The
// events are released as requests are accepted and compared in order with
// the event stream, under random idle and stall bursts on both sides.
// ----------------------------------------------------------------------------
module tb_lr_shift_reduce_engine_core;
    import lrsr_pkg::*;

    localparam int unsigned STACK_CAP   = 1024;
    localparam int unsigned TAIL_ITEMS  = 25;
    localparam int unsigned SETTLE_CYC  = 600;

    typedef struct {
        logic [47:0] data;
        bit          drain;
        int          nevents;
    } parse_request_t;

    typedef struct {
        event_kind_t kind;
        logic [7:0]  pushed;
        logic [6:0]  rule;
        logic [5:0]  symbol;
        logic [10:0] depth;
        logic        last;
    } parse_event_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // opcode, table_state, table_symbol, action_value, rule_index,
    // rule_length, rule_left_symbol, token_symbol (lowest bit first)
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // event_kind, pushed_state, reduced_rule, event_symbol, stack_depth
    logic [39:0] m_tdata;
    logic        m_tlast;

    lr_shift_reduce_engine_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Parser image kept by the predictor.
    logic [8:0] action_tbl [16384];
    bit         action_set [16384];
    logic [3:0] rule_len_tbl [128];
    logic [5:0] rule_left_tbl [128];
    bit         rule_set [128];
    logic [7:0] state_stk [STACK_CAP];
    int         depth;

    parse_request_t request_queue[$];
    parse_event_t   staged_events[$];
    parse_event_t   awaited_events[$];
    int             errors = 0;
    int             send_gap = 0;
    int             sink_stall = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("FAIL lr_shift_reduce_engine_core");
        $finish;
    end

    function automatic logic [47:0] pack_request(opcode_t op, logic [7:0] st,
            logic [5:0] sym, logic [8:0] val, logic [6:0] ri, logic [3:0] rl,
            logic [5:0] rls, logic [5:0] tok);
        return {tok, rls, rl, ri, val, sym, st, op};
    endfunction

    function automatic logic [47:0] noise48();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_request(logic [47:0] data, bit drain, int nev);
        parse_request_t req;
        req.data    = data;
        req.drain   = drain;
        req.nevents = nev;
        request_queue.push_back(req);
    endtask

    task automatic note_event(event_kind_t kind, logic [7:0] pushed, logic [6:0] rule,
            logic [5:0] symbol, int d, logic last);
        parse_event_t ev;
        ev.kind   = kind;
        ev.pushed = pushed;
        ev.rule   = rule;
        ev.symbol = symbol;
        ev.depth  = d[10:0];
        ev.last   = last;
        staged_events.push_back(ev);
    endtask

    task automatic write_action(logic [7:0] st, logic [5:0] sym, logic [8:0] val);
        logic [47:0] n;
        n = noise48();
        action_tbl[{st, sym}] = val;
        action_set[{st, sym}] = 1'b1;
        queue_request(pack_request(OP_WRITE_ACTION, st, sym, val, n[31:25], n[35:32],
                                   n[41:36], n[47:42]), 1'b0, 0);
    endtask

    task automatic write_rule(logic [6:0] ri, logic [3:0] len, logic [5:0] left);
        logic [47:0] n;
        n = noise48();
        rule_len_tbl[ri]  = len;
        rule_left_tbl[ri] = left;
        rule_set[ri]      = 1'b1;
        queue_request(pack_request(OP_WRITE_RULE, n[9:2], n[15:10], n[24:16], ri, len,
                                   left, n[47:42]), 1'b0, 0);
    endtask

    // Mostly shifts among a few states so the tables fill up, with some reductions.
    function automatic logic [8:0] pick_action();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 9'($urandom_range(0, 7));
        if (roll < 66) return 9'($urandom_range(0, 255));
        if (roll < 94) return 9'(-($urandom_range(0, 15) + 1));
        return 9'(-($urandom_range(0, 127) + 1));
    endfunction

    task automatic fill_action(logic [7:0] st, logic [5:0] sym);
        if (!action_set[{st, sym}]) write_action(st, sym, pick_action());
    endtask

    task automatic fill_rule(logic [6:0] ri);
        if (!rule_set[ri])
            write_rule(ri, ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                                       : 4'($urandom_range(0, 3)),
                       ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                                   : 6'($urandom_range(0, 7)));
    endtask

    // Walks the reductions and then the shift or error event for one token,
    // filling any table entry the walk needs before the token request goes out.
    task automatic parse_token(logic [5:0] tok, bit drain);
        logic [8:0]  act;
        logic [6:0]  ri;
        logic [5:0]  left;
        logic [7:0]  goto_st;
        logic [47:0] n;
        int          len;
        int          base;
        int          reductions;
        int          first;
        bit          finished;
        first      = staged_events.size();
        reductions = 0;
        finished   = 1'b0;
        while (!finished) begin
            fill_action(state_stk[depth - 1], tok);
            act = action_tbl[{state_stk[depth - 1], tok}];
            if (!act[8]) begin
                if (depth >= STACK_CAP) begin
                    note_event(EV_OVERFLOW, '0, '0, tok, depth, 1'b1);
                end else begin
                    state_stk[depth] = act[7:0];
                    depth++;
                    note_event(EV_SHIFT, act[7:0], '0, tok, depth, 1'b1);
                end
                finished = 1'b1;
            end else if (reductions >= REDUCE_LIMIT) begin
                note_event(EV_LIMIT, '0, '0, tok, depth, 1'b1);
                finished = 1'b1;
            end else begin
                ri = ~act[6:0];
                fill_rule(ri);
                len  = rule_len_tbl[ri];
                left = rule_left_tbl[ri];
                base = depth - len;
                if (len >= depth) begin
                    note_event(EV_UNDERFLOW, '0, '0, tok, depth, 1'b1);
                    finished = 1'b1;
                end else if (base >= STACK_CAP) begin
                    note_event(EV_OVERFLOW, '0, '0, tok, depth, 1'b1);
                    finished = 1'b1;
                end else begin
                    fill_action(state_stk[base - 1], left);
                    goto_st = action_tbl[{state_stk[base - 1], left}][7:0];
                    state_stk[base] = goto_st;
                    depth = base + 1;
                    note_event(EV_REDUCE, goto_st, ri, left, depth, 1'b0);
                    reductions++;
                end
            end
        end
        n = noise48();
        queue_request(pack_request(OP_TOKEN, n[9:2], n[15:10], n[24:16], n[31:25],
                                   n[35:32], n[41:36], tok), drain,
                      staged_events.size() - first);
    endtask

    task automatic end_input(bit drain);
        logic [47:0] n;
        n = noise48();
        note_event(EV_DONE, '0, '0, '0, depth, 1'b1);
        depth        = 1;
        state_stk[0] = '0;
        queue_request(pack_request(OP_END, n[9:2], n[15:10], n[24:16], n[31:25],
                                   n[35:32], n[41:36], n[47:42]), drain, 1);
    endtask

    // Stimulus generation and end of run.
    initial begin
        int roll;
        for (int i = 0; i < 16384; i++) action_set[i] = 1'b0;
        for (int i = 0; i < 128; i++) rule_set[i] = 1'b0;
        depth        = 1;
        state_stk[0] = '0;

        // A rule of length zero whose goto returns to the same state loops
        // until the reduction cap, growing the stack until it overflows.
        write_action(8'd0, 6'd10, 9'd1);
        write_action(8'd1, 6'd10, 9'h1FF);
        write_rule(7'd0, 4'd0, 6'd20);
        write_action(8'd1, 6'd20, 9'd1);
        parse_token(6'd10, 1'b0);
        repeat (17) parse_token(6'd10, 1'b0);
        // Shift on a full stack.
        write_action(8'd1, 6'd11, 9'd255);
        parse_token(6'd11, 1'b0);
        end_input(1'b0);
        // Longest rule on a shallow stack underflows.
        write_rule(7'd127, 4'd15, 6'd63);
        write_action(8'd0, 6'd12, 9'h180);
        parse_token(6'd12, 1'b0);
        // Field extremes and a negative goto entry.
        write_action(8'd0, 6'd63, 9'd255);
        write_action(8'd255, 6'd63, 9'h1FE);
        write_rule(7'd1, 4'd1, 6'd5);
        write_action(8'd0, 6'd5, 9'h180);
        parse_token(6'd63, 1'b0);
        parse_token(6'd63, 1'b0);
        end_input(1'b1);

        for (int i = 0; i < 90; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 72)
                parse_token(($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63))
                                                        : 6'($urandom_range(0, 7)),
                            (i % 40) == 20);
            else if (roll < 80)
                end_input(1'b0);
            else if (roll < 90)
                write_action(8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                             9'($urandom_range(0, 383) - 128));
            else
                write_rule(7'($urandom_range(0, 127)), 4'($urandom_range(0, 15)),
                           6'($urandom_range(0, 63)));
        end
        end_input(1'b0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (request_queue.size() != 0 || awaited_events.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS lr_shift_reduce_engine_core");
        end else begin
            $display("FAIL lr_shift_reduce_engine_core");
        end
        $finish;
    end

    // Request driver: releases the events of each accepted request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                for (int k = 0; k < request_queue[0].nevents; k++)
                    awaited_events.push_back(staged_events.pop_front());
                void'(request_queue.pop_front());
                if (request_queue.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0)
                    send_gap = $urandom_range(1, 15);
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (request_queue.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (request_queue[0].drain && awaited_events.size() != 0) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= request_queue[0].data;
                end
            end
        end
    end

    // Event monitor with random stalls.
    always @(posedge aclk) begin
        parse_event_t exp_ev;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_events.size() == 0) begin
                $display("%0t: unexpected event %h last %b", $time, m_tdata, m_tlast);
                errors++;
            end else begin
                exp_ev = awaited_events.pop_front();
                if (m_tdata[2:0] != exp_ev.kind || m_tdata[10:3] != exp_ev.pushed ||
                    m_tdata[17:11] != exp_ev.rule || m_tdata[23:18] != exp_ev.symbol ||
                    m_tdata[34:24] != exp_ev.depth || m_tlast != exp_ev.last) begin
                    $display("%0t: mismatch expected kind %0d state %0d rule %0d sym %0d depth %0d last %b, actual kind %0d state %0d rule %0d sym %0d depth %0d last %b",
                             $time, exp_ev.kind, exp_ev.pushed, exp_ev.rule, exp_ev.symbol,
                             exp_ev.depth, exp_ev.last, m_tdata[2:0], m_tdata[10:3],
                             m_tdata[17:11], m_tdata[23:18], m_tdata[34:24], m_tlast);
                    errors++;
                end
            end
        end
        if (sink_stall > 0) begin
            sink_stall--;
            m_tready <= 1'b0;
        end else if (request_queue.size() > TAIL_ITEMS && $urandom_range(0, 19) == 0) begin
            sink_stall = $urandom_range(0, 14);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

endmodule

### lr_shift_reduce_engine_core.f
hw/rtl/lrsr_pkg.sv
hw/rtl/lrsr_ram.sv
hw/rtl/lr_shift_reduce_engine_core.sv
bench/tb_lr_shift_reduce_engine_core.sv
